// ===== rtl/core/ppdcs_pkg.sv =====
// shared types, constants and codes for the peer packet dedup and clock sync block
package ppdcs_pkg;

  localparam int unsigned PEER_SLOTS = 4;
  localparam int unsigned SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(PEER_SLOTS + 1);

  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned GAP_W      = 8;
  localparam int unsigned VERDICT_W  = 3;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ID_W-1:0]  NODE_ID_RST      = 8'd1;
  localparam logic [WIN_W-1:0] ALIVE_WINDOW_RST = 16'd3000;
  localparam logic [GAP_W-1:0] REBOOT_GAP_RST   = 8'd16;

  typedef enum logic [TYPE_W-1:0] {
    PKT_EVENT     = 2'd0,
    PKT_MOTION    = 2'd1,
    PKT_HEARTBEAT = 2'd2,
    PKT_OTHER     = 2'd3
  } pkt_type_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT  = 3'd0,
    VERDICT_OWN     = 3'd1,
    VERDICT_FULL    = 3'd2,
    VERDICT_DUP     = 3'd3,
    VERDICT_UNKNOWN = 3'd4
  } verdict_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_ARM      = 2'd2,
    ACT_OFFSET   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ID      = 2'd0,
    REG_ALIVE_WINDOW = 2'd1,
    REG_REBOOT_GAP   = 2'd2
  } cfg_reg_e;

  // one peer table row
  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [WORD_W-1:0] event_seen;
    logic [WORD_W-1:0] motion_seen;
    logic [WORD_W-1:0] hb_seen;
    logic [WORD_W-1:0] high_mark;
    logic [WORD_W-1:0] uptime;
    logic [WORD_W-1:0] last_seen;
  } peer_rec_t;

  localparam int unsigned PEER_REC_W = $bits(peer_rec_t);

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_SCAN_RD  = 3'd1,
    OP_SCAN_CHK = 3'd2,
    OP_SLOT_RD  = 3'd3,
    OP_STAGE    = 3'd4,
    OP_COMMIT   = 3'd5,
    OP_OWN      = 3'd6,
    OP_FULL     = 3'd7
  } dp_op_e;

  typedef struct packed {
    logic   latch;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic own;
    logic empty;
    logic scan_last;
    logic found;
    logic full;
    logic res_free;
  } dp_status_t;

endpackage

// ===== rtl/core/ppdcs_if.sv =====
// channel interfaces: packet header in, result out, register write
interface ppdcs_in_if import ppdcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] pkt_type;
  logic [ID_W-1:0]   origin_id;
  logic [WORD_W-1:0] seq_num;
  logic [WORD_W-1:0] value_ms;
  logic              payload_ok;
  logic [WORD_W-1:0] now_ms;

  modport source (output valid, pkt_type, origin_id, seq_num, value_ms, payload_ok, now_ms,
                  input ready);
  modport sink   (input valid, pkt_type, origin_id, seq_num, value_ms, payload_ok, now_ms,
                  output ready);
endinterface

interface ppdcs_out_if import ppdcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VERDICT_W-1:0]     verdict;
  logic [ACTION_W-1:0]      action;
  logic [WORD_W-1:0]        motion_start_ms;
  logic signed [WORD_W-1:0] clock_offset_out;

  modport source (output valid, verdict, action, motion_start_ms, clock_offset_out,
                  input ready);
  modport sink   (input valid, verdict, action, motion_start_ms, clock_offset_out,
                  output ready);
endinterface

interface ppdcs_cfg_if import ppdcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ppdcs_ram.sv =====
// generic single write port ram with registered read
module ppdcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ppdcs_datapath.sv =====
// peer table, config registers, dedup and clock offset datapath, result register
module ppdcs_datapath import ppdcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic [TYPE_W-1:0]        pkt_type_i,
  input  logic [ID_W-1:0]          origin_id_i,
  input  logic [WORD_W-1:0]        seq_num_i,
  input  logic [WORD_W-1:0]        value_ms_i,
  input  logic                     payload_ok_i,
  input  logic [WORD_W-1:0]        now_ms_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [VERDICT_W-1:0]     verdict_o,
  output logic [ACTION_W-1:0]      action_o,
  output logic [WORD_W-1:0]        motion_start_ms_o,
  output logic signed [WORD_W-1:0] clock_offset_out_o
);

  // config registers
  logic [ID_W-1:0]  node_id_q;
  logic [WIN_W-1:0] window_q;
  logic [GAP_W-1:0] gap_q;

  // latched header
  pkt_type_e         type_q;
  logic [ID_W-1:0]   origin_q;
  logic [WORD_W-1:0] seq_q;
  logic [WORD_W-1:0] value_q;
  logic              pok_q;
  logic [WORD_W-1:0] now_q;

  // table bookkeeping
  logic [CNT_W-1:0]  peer_count_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] slot_q;
  logic              found_q;
  logic              lower_q;
  peer_rec_t         rec_q;
  logic [WORD_W-1:0] offset_q;

  // result register
  logic              res_valid_q;
  verdict_e          res_verdict_q;
  action_e           res_action_q;
  logic [WORD_W-1:0] res_start_q;
  logic [WORD_W-1:0] res_offset_q;

  // ram
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [PEER_REC_W-1:0] ram_rdata;
  peer_rec_t         rd_rec;
  peer_rec_t         wr_rec;

  // scan and stage logic
  logic              alive;
  logic              match;
  peer_rec_t         src_rec;
  peer_rec_t         stage_rec;
  logic              reboot;

  // commit logic
  logic [WORD_W-1:0] hw_new;
  logic [WORD_W-1:0] seen_cur;
  logic              dup;
  logic              adopt;
  verdict_e          c_verdict;
  action_e           c_action;
  logic [WORD_W-1:0] c_start;

  assign ram_re    = (cmd_i.op == OP_SCAN_RD) || (cmd_i.op == OP_SLOT_RD);
  assign ram_raddr = (cmd_i.op == OP_SLOT_RD) ? slot_q : idx_q;
  assign rd_rec    = peer_rec_t'(ram_rdata);

  ppdcs_ram #(
    .WIDTH (PEER_REC_W),
    .DEPTH (PEER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_COMMIT),
    .waddr_i (slot_q),
    .wdata_i (PEER_REC_W'(wr_rec)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // peer liveness and identity of the row just read
  assign alive = (now_q - rd_rec.last_seen) < {{(WORD_W-WIN_W){1'b0}}, window_q};
  assign match = rd_rec.ident == origin_q;

  // stage row: stored one or fresh for a new sender; counters cleared on reboot
  always_comb begin
    src_rec = '0;
    src_rec.ident = origin_q;
    if (found_q) begin
      src_rec = rd_rec;
    end
    reboot = (src_rec.high_mark != '0) &&
             ((seq_q + {{(WORD_W-GAP_W){1'b0}}, gap_q}) < src_rec.high_mark);
    stage_rec = src_rec;
    if (reboot) begin
      stage_rec.event_seen  = '0;
      stage_rec.motion_seen = '0;
      stage_rec.hb_seen     = '0;
      stage_rec.high_mark   = '0;
    end
  end

  // dedup, row update and result
  always_comb begin
    hw_new = (seq_q > rec_q.high_mark) ? seq_q : rec_q.high_mark;
    unique case (type_q)
      PKT_EVENT:     seen_cur = rec_q.event_seen;
      PKT_MOTION:    seen_cur = rec_q.motion_seen;
      PKT_HEARTBEAT: seen_cur = rec_q.hb_seen;
      default:       seen_cur = '0;
    endcase
    dup   = (seen_cur != '0) && (seq_q <= seen_cur);
    adopt = (type_q == PKT_HEARTBEAT) && !dup && (origin_q < node_id_q) && !lower_q &&
            (window_q != '0);

    wr_rec           = rec_q;
    wr_rec.last_seen = now_q;
    wr_rec.high_mark = hw_new;
    c_verdict        = dup ? VERDICT_DUP : VERDICT_ACCEPT;
    c_action         = ACT_NONE;
    c_start          = '0;
    unique case (type_q)
      PKT_EVENT: begin
        if (!dup) begin
          wr_rec.event_seen = seq_q;
          c_action          = ACT_DISPATCH;
        end
      end
      PKT_MOTION: begin
        if (!dup) begin
          wr_rec.motion_seen = seq_q;
          if (pok_q) begin
            c_action = ACT_ARM;
            c_start  = now_q + value_q;
          end
        end
      end
      PKT_HEARTBEAT: begin
        if (!dup) begin
          wr_rec.hb_seen = seq_q;
          wr_rec.uptime  = value_q;
          if (adopt) begin
            c_action = ACT_OFFSET;
          end
        end
      end
      default: begin
        c_verdict = VERDICT_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= NODE_ID_RST;
      window_q  <= ALIVE_WINDOW_RST;
      gap_q     <= REBOOT_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NODE_ID:      node_id_q <= cfg_data_i[ID_W-1:0];
        REG_ALIVE_WINDOW: window_q  <= cfg_data_i[WIN_W-1:0];
        REG_REBOOT_GAP:   gap_q     <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q   <= pkt_type_e'(pkt_type_i);
      origin_q <= origin_id_i;
      seq_q    <= seq_num_i;
      value_q  <= value_ms_i;
      pok_q    <= payload_ok_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.op == OP_STAGE) begin
      rec_q <= stage_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_count_q <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      lower_q      <= 1'b0;
      offset_q     <= '0;
    end else begin
      if (cmd_i.latch) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        lower_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_SCAN_CHK: begin
          idx_q <= idx_q + SLOT_W'(1);
          if (match) begin
            found_q <= 1'b1;
            slot_q  <= idx_q;
          end else if (alive && (rd_rec.ident < origin_q)) begin
            lower_q <= 1'b1;
          end
        end
        OP_STAGE: begin
          if (!found_q) begin
            slot_q       <= SLOT_W'(peer_count_q);
            peer_count_q <= peer_count_q + CNT_W'(1);
          end
        end
        OP_COMMIT: begin
          if (adopt) begin
            offset_q <= value_q - now_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if ((cmd_i.op == OP_COMMIT) || (cmd_i.op == OP_OWN) || (cmd_i.op == OP_FULL)) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_COMMIT: begin
        res_verdict_q <= c_verdict;
        res_action_q  <= c_action;
        res_start_q   <= c_start;
        res_offset_q  <= adopt ? (value_q - now_q) : offset_q;
      end
      OP_OWN, OP_FULL: begin
        res_verdict_q <= (cmd_i.op == OP_OWN) ? VERDICT_OWN : VERDICT_FULL;
        res_action_q  <= ACT_NONE;
        res_start_q   <= '0;
        res_offset_q  <= offset_q;
      end
      default: ;
    endcase
  end

  assign status_o.own       = origin_q == node_id_q;
  assign status_o.empty     = peer_count_q == '0;
  assign status_o.scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == peer_count_q;
  assign status_o.found     = found_q;
  assign status_o.full      = peer_count_q == CNT_W'(PEER_SLOTS);
  assign status_o.res_free  = !res_valid_q || out_ready_i;

  assign out_valid_o        = res_valid_q;
  assign verdict_o          = res_verdict_q;
  assign action_o           = res_action_q;
  assign motion_start_ms_o  = res_start_q;
  assign clock_offset_out_o = $signed(res_offset_q);

endmodule

// ===== rtl/core/ppdcs_ctrl.sv =====
// sequencer for header check, table scan, row update and result hand-off
module ppdcs_ctrl import ppdcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SLOT_RD,
    S_STAGE,
    S_COMMIT,
    S_OWN,
    S_FULL
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_comb begin
    cmd_o.latch = ready_q && in_valid_i;
    unique case (state_q)
      S_SCAN_RD:  cmd_o.op = OP_SCAN_RD;
      S_SCAN_CHK: cmd_o.op = OP_SCAN_CHK;
      S_SLOT_RD:  cmd_o.op = OP_SLOT_RD;
      S_STAGE:    cmd_o.op = OP_STAGE;
      S_COMMIT:   cmd_o.op = status_i.res_free ? OP_COMMIT : OP_NONE;
      S_OWN:      cmd_o.op = status_i.res_free ? OP_OWN : OP_NONE;
      S_FULL:     cmd_o.op = status_i.res_free ? OP_FULL : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ready_q && in_valid_i) begin
            state_q <= S_CHECK;
            ready_q <= 1'b0;
          end
        end
        S_CHECK: begin
          if (status_i.own) begin
            state_q <= S_OWN;
          end else if (status_i.empty) begin
            state_q <= S_STAGE;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          state_q <= status_i.scan_last ? S_DECIDE : S_SCAN_RD;
        end
        S_DECIDE: begin
          if (status_i.found) begin
            state_q <= S_SLOT_RD;
          end else if (status_i.full) begin
            state_q <= S_FULL;
          end else begin
            state_q <= S_STAGE;
          end
        end
        S_SLOT_RD: state_q <= S_STAGE;
        S_STAGE:   state_q <= S_COMMIT;
        S_COMMIT, S_OWN, S_FULL: begin
          if (status_i.res_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ===== rtl/core/peer_packet_dedup_clock_sync.sv =====
// top level: peer packet deduplication and clock sync
//
// pkt_i carries one parsed sync header per beat (type, origin, sequence,
// value, payload flag, arrival time). res_o returns exactly one result beat
// per header: verdict, action, motion start time and the clock offset after
// the packet. cfg_i writes node_id, alive_window_ms and reboot_gap by index;
// it is always ready and should only be used while no packet is in flight.
//
// one header is in work at a time. the scan reads one peer row per read
// and check state pair. from accept to result valid: check then own for an
// own packet; check, stage, commit with an empty table; else the scan and
// decide, then full if the table is full, stage and commit for a new sender,
// slot read, stage, commit for a known one; then idle before the next accept.
//
// the result sits in an output register: pkt_i takes the next header while
// a result waits on a stalled receiver; the following result then waits in
// the sequencer until the register frees up.
// reset clears the peer count, the clock offset, the result valid and loads
// the register defaults; the peer rows need no clearing.
module peer_packet_dedup_clock_sync import ppdcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppdcs_in_if.sink    pkt_i,
  ppdcs_out_if.source res_o,
  ppdcs_cfg_if.sink   cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never stall
  assign cfg_i.ready = 1'b1;

  ppdcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (pkt_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppdcs_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .pkt_type_i         (pkt_i.pkt_type),
    .origin_id_i        (pkt_i.origin_id),
    .seq_num_i          (pkt_i.seq_num),
    .value_ms_i         (pkt_i.value_ms),
    .payload_ok_i       (pkt_i.payload_ok),
    .now_ms_i           (pkt_i.now_ms),
    .cfg_we_i           (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .out_ready_i        (res_o.ready),
    .out_valid_o        (res_o.valid),
    .verdict_o          (res_o.verdict),
    .action_o           (res_o.action),
    .motion_start_ms_o  (res_o.motion_start_ms),
    .clock_offset_out_o (res_o.clock_offset_out)
  );

`ifndef SYNTH
  // one header in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_i.valid && pkt_i.ready |=> !pkt_i.ready)
    else $error("header accepted while another is in work");

  // rejected or duplicate beats carry no action
  a_reject_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.verdict != VERDICT_ACCEPT) |-> res_o.action == ACT_NONE)
    else $error("action on a rejected beat");

  // start time only with a motion arm
  a_start_only_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.action != ACT_ARM) |-> res_o.motion_start_ms == '0)
    else $error("motion start without arm");

  // the row write only happens with a result register that can take it
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_COMMIT) |=> res_o.valid)
    else $error("commit without result");
`endif

endmodule

// ===== test/tb_peer_packet_dedup_clock_sync.sv =====
// testbench for the peer packet dedup and clock sync block: header stream, result checks
module tb_peer_packet_dedup_clock_sync;
  import ppdcs_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  // covers the slowest header: a full scan, a known sender's row update, back to idle
  localparam int SETTLE_CYCLES  = 2 * PEER_SLOTS + 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 130;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTS    = 10;

  // one parsed sync header as it crosses pkt_i
  typedef struct packed {
    pkt_type_e         ptype;
    logic [ID_W-1:0]   origin;
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] value;
    logic              ok;
    logic [WORD_W-1:0] now;
  } header_t;

  // one result beat as it crosses res_o
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [ACTION_W-1:0]  action;
    logic [WORD_W-1:0]    start;
    logic [WORD_W-1:0]    offset;
  } outcome_t;

  // mirrors the peer table and clock offset, predicts one outcome per header
  class peer_sync_scoreboard;
    logic [ID_W-1:0]   node_id;
    logic [WIN_W-1:0]  alive_window;
    logic [GAP_W-1:0]  reboot_gap;
    int unsigned       peer_count;
    logic [ID_W-1:0]   ident       [PEER_SLOTS];
    logic [WORD_W-1:0] event_seen  [PEER_SLOTS];
    logic [WORD_W-1:0] motion_seen [PEER_SLOTS];
    logic [WORD_W-1:0] hb_seen     [PEER_SLOTS];
    logic [WORD_W-1:0] high_mark   [PEER_SLOTS];
    logic [WORD_W-1:0] uptime      [PEER_SLOTS];
    logic [WORD_W-1:0] last_seen   [PEER_SLOTS];
    logic [WORD_W-1:0] offset;
    outcome_t          pending_verdicts[$];
    int unsigned       n_headers;
    int unsigned       n_results;
    int unsigned       n_errors;
    int unsigned       verdict_hits[5];
    int unsigned       action_hits[4];

    function new();
      node_id      = NODE_ID_RST;
      alive_window = ALIVE_WINDOW_RST;
      reboot_gap   = REBOOT_GAP_RST;
      peer_count   = 0;
      offset       = '0;
      n_headers    = 0;
      n_results    = 0;
      n_errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (cfg_reg_e'(index))
        REG_NODE_ID:      node_id      = data[ID_W-1:0];
        REG_ALIVE_WINDOW: alive_window = data[WIN_W-1:0];
        REG_REBOOT_GAP:   reboot_gap   = data[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    // zero means nothing seen yet, so anything passes
    function bit is_new_seq(logic [WORD_W-1:0] seen, logic [WORD_W-1:0] seq);
      return seen == '0 || seq > seen;
    endfunction

    function void note_header(header_t h);
      outcome_t          want;
      int                slot;
      logic [ID_W-1:0]   low;
      logic [WORD_W-1:0] age;
      logic [WORD_W-1:0] bumped;
      want.verdict = VERDICT_ACCEPT;
      want.action  = ACT_NONE;
      want.start   = '0;
      slot         = -1;
      if (h.origin == node_id) begin
        want.verdict = VERDICT_OWN;
      end else begin
        for (int i = 0; i < peer_count; i++)
          if (slot < 0 && ident[i] == h.origin) slot = i;
        if (slot >= 0) begin
          last_seen[slot] = h.now;
        end else if (peer_count < PEER_SLOTS) begin
          slot              = peer_count;
          ident[slot]       = h.origin;
          event_seen[slot]  = '0;
          motion_seen[slot] = '0;
          hb_seen[slot]     = '0;
          high_mark[slot]   = '0;
          uptime[slot]      = '0;
          last_seen[slot]   = h.now;
          peer_count++;
        end
        if (slot < 0) begin
          want.verdict = VERDICT_FULL;
        end else begin
          // sequence far below the high mark: sender restarted
          bumped = h.seq + reboot_gap;
          if (high_mark[slot] != '0 && bumped < high_mark[slot]) begin
            event_seen[slot]  = '0;
            motion_seen[slot] = '0;
            hb_seen[slot]     = '0;
            high_mark[slot]   = '0;
          end
          if (h.seq > high_mark[slot]) high_mark[slot] = h.seq;
          case (h.ptype)
            PKT_EVENT: begin
              if (is_new_seq(event_seen[slot], h.seq)) begin
                event_seen[slot] = h.seq;
                want.action      = ACT_DISPATCH;
              end else begin
                want.verdict = VERDICT_DUP;
              end
            end
            PKT_MOTION: begin
              if (is_new_seq(motion_seen[slot], h.seq)) begin
                motion_seen[slot] = h.seq;
                if (h.ok) begin
                  want.action = ACT_ARM;
                  want.start  = h.now + h.value;
                end
              end else begin
                want.verdict = VERDICT_DUP;
              end
            end
            PKT_HEARTBEAT: begin
              if (is_new_seq(hb_seen[slot], h.seq)) begin
                hb_seen[slot] = h.seq;
                uptime[slot]  = h.value;
                low           = node_id;
                for (int i = 0; i < peer_count; i++) begin
                  age = h.now - last_seen[i];
                  if (age < alive_window && ident[i] < low) low = ident[i];
                end
                if (h.origin == low && h.origin < node_id) begin
                  offset      = h.value - h.now;
                  want.action = ACT_OFFSET;
                end
              end else begin
                want.verdict = VERDICT_DUP;
              end
            end
            default: want.verdict = VERDICT_UNKNOWN;
          endcase
        end
      end
      want.offset = offset;
      verdict_hits[want.verdict]++;
      action_hits[want.action]++;
      n_headers++;
      pending_verdicts.push_back(want);
    endfunction

    function void check_verdict(outcome_t got);
      outcome_t want;
      n_results++;
      if (pending_verdicts.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] result beat with nothing pending: verdict %0d action %0d",
                   $time, got.verdict, got.action);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict || got.action !== want.action ||
          got.start !== want.start || got.offset !== want.offset) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] result %0d mismatch (exp/got): verdict %0d/%0d action %0d/%0d %s",
                   $time, n_results, want.verdict, got.verdict, want.action, got.action,
                   $sformatf("start %h/%h offset %h/%h", want.start, got.start,
                             want.offset, got.offset));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ppdcs_in_if  pkt_if ();
  ppdcs_out_if res_if ();
  ppdcs_cfg_if cfg_if ();

  peer_packet_dedup_clock_sync dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  peer_sync_scoreboard sb;

  // idling knobs shared by the sender task and the receiver process
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int          hold_left     = 0;

  // the four peers that fill the table, in the order the directed part adds them
  logic [ID_W-1:0]   roster  [PEER_SLOTS] = '{8'd5, 8'd0, 8'd255, 8'd77};
  // per-peer sender sequence counters and the local arrival clock
  logic [WORD_W-1:0] seq_ctr [PEER_SLOTS];
  logic [WORD_W-1:0] cur_now;

  header_t  taken_hdr;
  outcome_t shown_res;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // receiver: random stalls, plus a long hold-off when the stimulus asks for one
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: register writes and headers feed the predictor, result beats are checked.
  // a result always belongs to a header accepted at an earlier edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        shown_res.verdict = res_if.verdict;
        shown_res.action  = res_if.action;
        shown_res.start   = res_if.motion_start_ms;
        shown_res.offset  = res_if.clock_offset_out;
        sb.check_verdict(shown_res);
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (pkt_if.valid && pkt_if.ready) begin
        taken_hdr.ptype  = pkt_type_e'(pkt_if.pkt_type);
        taken_hdr.origin = pkt_if.origin_id;
        taken_hdr.seq    = pkt_if.seq_num;
        taken_hdr.value  = pkt_if.value_ms;
        taken_hdr.ok     = pkt_if.payload_ok;
        taken_hdr.now    = pkt_if.now_ms;
        sb.note_header(taken_hdr);
      end
    end
  end

  function automatic header_t hdr(pkt_type_e ptype, logic [ID_W-1:0] origin,
                                  logic [WORD_W-1:0] seq, logic [WORD_W-1:0] value,
                                  logic ok, logic [WORD_W-1:0] now);
    header_t h;
    h.ptype  = ptype;
    h.origin = origin;
    h.seq    = seq;
    h.value  = value;
    h.ok     = ok;
    h.now    = now;
    return h;
  endfunction

  // offers one header and returns at the edge that takes it; valid stays high
  // so that back-to-back headers never lower and raise it in the same step
  task automatic send_packet(input header_t h);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    pkt_if.valid      <= 1'b1;
    pkt_if.pkt_type   <= h.ptype;
    pkt_if.origin_id  <= h.origin;
    pkt_if.seq_num    <= h.seq;
    pkt_if.value_ms   <= h.value;
    pkt_if.payload_ok <= h.ok;
    pkt_if.now_ms     <= h.now;
    do @(posedge clk_i); while (!pkt_if.ready);
  endtask

  // sender pauses until every pending result is back, then lets the block settle;
  // the first edge lets the monitor log the header taken at the current one
  task automatic drain_results();
    pkt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers back to back; upper data bits of the 8 bit
  // registers are random since only the low byte counts
  task automatic load_registers(input logic [ID_W-1:0] node, input logic [WIN_W-1:0] window,
                                input logic [GAP_W-1:0] gap);
    cfg_reg_e              which [3] = '{REG_NODE_ID, REG_ALIVE_WINDOW, REG_REBOOT_GAP};
    logic [CFG_DATA_W-1:0] data  [3];
    data[0] = {8'($urandom_range(0, 255)), node};
    data[1] = window;
    data[2] = {8'($urandom_range(0, 255)), gap};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= which[i];
      cfg_if.data  <= data[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // random header: mostly well-formed traffic from the known peers, with
  // replays, sender restarts, own packets and strangers mixed in.
  // counted is set for headers from a known peer that is not the node itself
  task automatic next_header(output header_t h, output bit counted);
    int unsigned r;
    int          k;
    k = -1;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      k        = $urandom_range(0, PEER_SLOTS - 1);
      h.origin = roster[k];
    end else if (r < 80) begin
      h.origin = sb.node_id;
    end else begin
      h.origin = 8'($urandom_range(0, 255));
    end
    counted = (k >= 0) && (h.origin != sb.node_id);

    r = $urandom_range(0, 99);
    if (r < 30)      h.ptype = PKT_EVENT;
    else if (r < 60) h.ptype = PKT_MOTION;
    else if (r < 90) h.ptype = PKT_HEARTBEAT;
    else             h.ptype = PKT_OTHER;

    if (k < 0) begin
      h.seq = $urandom();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 66)      seq_ctr[k] += $urandom_range(1, 3);
      else if (r < 72) seq_ctr[k] += $urandom_range(4, 400);
      else if (r < 78) seq_ctr[k] = $urandom_range(0, 8);   // sender restart
      else if (r < 81) seq_ctr[k] = $urandom();
      if (r >= 81 && r < 95) h.seq = seq_ctr[k] - $urandom_range(0, 4);   // replay
      else if (r >= 95)      h.seq = $urandom();
      else                   h.seq = seq_ctr[k];
    end

    if (h.ptype == PKT_MOTION && $urandom_range(0, 99) < 80) h.value = $urandom_range(0, 5000);
    else h.value = $urandom();
    h.ok = ($urandom_range(0, 99) < 80);

    // arrival time mostly creeps forward, so peers drift in and out of the window
    r = $urandom_range(0, 99);
    if (r < 85)      cur_now += $urandom_range(0, 1200);
    else if (r < 93) cur_now += $urandom_range(0, 70000);
    else if (r >= 97) cur_now = $urandom();
    h.now = cur_now;
  endtask

  initial begin
    header_t     h;
    bit          counted;
    int unsigned n;
    rst_ni            = 1'b0;
    pkt_if.valid      = 1'b0;
    pkt_if.pkt_type   = '0;
    pkt_if.origin_id  = '0;
    pkt_if.seq_num    = '0;
    pkt_if.value_ms   = '0;
    pkt_if.payload_ok = 1'b0;
    pkt_if.now_ms     = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_NODE_ID;
    cfg_if.data       = '0;
    sb                = new();
    foreach (seq_ctr[i]) seq_ctr[i] = 32'd200;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 55;

    // directed part at reset register values: node 1, window 3000, gap 16
    send_packet(hdr(PKT_EVENT,     8'd5,   32'd1,  32'd0,          1'b1, 32'd1000));
    // same event again is a duplicate
    send_packet(hdr(PKT_EVENT,     8'd5,   32'd1,  32'd0,          1'b1, 32'd1010));
    // motion with the largest lead wraps the start time
    send_packet(hdr(PKT_MOTION,    8'd0,   32'd10, 32'hFFFF_FFFF,  1'b1, 32'd1020));
    // motion without a usable payload: taken, no arm
    send_packet(hdr(PKT_MOTION,    8'd0,   32'd11, 32'd250,        1'b0, 32'd1030));
    // peer 0 is the lowest alive id and below node 1: offset adopted
    send_packet(hdr(PKT_HEARTBEAT, 8'd0,   32'd12, 32'h8000_0000,  1'b1, 32'd1040));
    send_packet(hdr(PKT_HEARTBEAT, 8'd0,   32'd12, 32'd5,          1'b1, 32'd1050));
    // adoption again with an unchanged offset still reports the action
    send_packet(hdr(PKT_HEARTBEAT, 8'd0,   32'd13, 32'h8000_0010,  1'b0, 32'd1056));
    // own packet
    send_packet(hdr(PKT_EVENT,     8'd1,   32'd7,  32'd0,          1'b1, 32'd1060));
    // sequence zero never counts as seen, so it passes twice
    send_packet(hdr(PKT_HEARTBEAT, 8'd255, 32'd0,  32'hFFFF_FFFF,  1'b1, 32'd1070));
    send_packet(hdr(PKT_HEARTBEAT, 8'd255, 32'd0,  32'd0,          1'b0, 32'd1080));
    // unknown type after the bookkeeping, fills the last slot
    send_packet(hdr(PKT_OTHER,     8'd77,  32'd5,  32'd0,          1'b1, 32'd1090));
    // table full
    send_packet(hdr(PKT_EVENT,     8'd200, 32'd1,  32'd0,          1'b1, 32'd1100));
    send_packet(hdr(PKT_EVENT,     8'd5,   32'd100, 32'd0,         1'b1, 32'd1110));
    // inside the reboot gap: just a duplicate
    send_packet(hdr(PKT_EVENT,     8'd5,   32'd90, 32'd0,          1'b1, 32'd1120));
    // beyond the gap: sender restarted, counters cleared
    send_packet(hdr(PKT_EVENT,     8'd5,   32'd83, 32'd0,          1'b1, 32'd1130));
    send_packet(hdr(PKT_EVENT,     8'd5,   32'hFFFF_FFF8, 32'd0,   1'b1, 32'd1140));
    // sequence plus gap wraps to zero and reads as a restart
    send_packet(hdr(PKT_EVENT,     8'd5,   32'hFFFF_FFF0, 32'd0,   1'b1, 32'd1150));
    send_packet(hdr(PKT_MOTION,    8'd77,  32'hFFFF_FFFF, 32'd0,   1'b1, 32'hFFFF_FFFF));
    // arrival time wraps to zero
    send_packet(hdr(PKT_HEARTBEAT, 8'd0,   32'd14, 32'd0,          1'b1, 32'd0));
    send_packet(hdr(PKT_OTHER,     8'd200, 32'd2,  32'd9,          1'b1, 32'd20));
    send_packet(hdr(PKT_OTHER,     8'd1,   32'd3,  32'd9,          1'b0, 32'd30));
    send_packet(hdr(PKT_MOTION,    8'd77,  32'hFFFF_FFFF, 32'd3,   1'b1, 32'd40));
    drain_results();

    cur_now = 32'd2000;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_registers(8'd100, 16'd3000, 8'd16);
        1: load_registers(8'd255, 16'd1, 8'd0);
        2: load_registers(8'd1, 16'd65535, 8'd255);
        3: load_registers(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                          8'($urandom_range(0, 255)));
        4: load_registers(8'd77, 16'd1500, 8'd4);
        default: load_registers(8'd200, 16'd3000, 8'd16);
      endcase
      // first both idle one way, then the other, then the last two phases at full rate
      if (p < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 55;
      end else if (p < 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // arrival clock near the top in one phase, sequences near the top in another
      if (p == 1) cur_now = 32'hFFFF_F000;
      if (p == 2) foreach (seq_ctr[i]) seq_ctr[i] = 32'hFFFF_FFF0;

      n = 0;
      while (n < PHASE_ITEMS) begin
        next_header(h, counted);
        send_packet(h);
        if (counted) begin
          n++;
          // long receiver hold-off while headers keep coming: the block backs up
          if ((p == 0 || p == 4) && n == 50) hold_request = 1'b1;
        end
      end
      drain_results();
    end

    $display("covered %0d headers over 7 register settings: %0d accepted, %0d own, %0d full, %s",
             sb.n_headers, sb.verdict_hits[VERDICT_ACCEPT], sb.verdict_hits[VERDICT_OWN],
             sb.verdict_hits[VERDICT_FULL],
             $sformatf("%0d duplicate, %0d unknown type", sb.verdict_hits[VERDICT_DUP],
                       sb.verdict_hits[VERDICT_UNKNOWN]));
    $display("%0d event dispatches, %0d motion arms, %0d offset adoptions; %0d mismatches",
             sb.action_hits[ACT_DISPATCH], sb.action_hits[ACT_ARM], sb.action_hits[ACT_OFFSET],
             sb.n_errors);
    if (sb.pending_verdicts.size() != 0)
      $display("%0d results never arrived", sb.pending_verdicts.size());
    if (sb.n_errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", sb.pending_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
